// ----- rtl/acwt_pkg.sv -----
// shared types and constants for the average cost win tracker
// no dependencies; imported by acwt_div and average_cost_win_tracker
`timescale 1ns / 1ps

package acwt_pkg;

    // field widths
    localparam int SYM_W    = 8;
    localparam int QTY_W    = 24;
    localparam int PRICE_W  = 32;
    localparam int CNT_W    = 32;
    localparam int RATE_W   = 17;

    // default table depth
    localparam int DEF_SYMBOL_COUNT = 256;

    // fill side codes
    localparam logic SIDE_BUY  = 1'b0;
    localparam logic SIDE_SELL = 1'b1;

    // divider sizing: remainder stays below a 33-bit divisor
    localparam int DIV_REM_W   = 33;
    localparam int DIV_LOW_W   = 32;
    localparam int DIV_STEPS_W = 6;
    localparam int COST_STEPS  = 32;
    localparam int RATE_STEPS  = 17;

    typedef struct packed {
        logic [SYM_W-1:0]   symbol_id;
        logic               func;
        logic [QTY_W-1:0]   quantity;
        logic [PRICE_W-1:0] price;
    } t_fill;

    typedef struct packed {
        logic [CNT_W-1:0]   closed_count;
        logic [CNT_W-1:0]   win_count;
        logic [RATE_W-1:0]  win_frac;
        logic               trade_closed;
        logic               trade_won;
        logic [CNT_W-1:0]   held_quantity;
        logic [PRICE_W-1:0] average_cost;
    } t_result;

    // divider request: start, initial remainder, bits still to shift in, divisor, step count
    typedef struct packed {
        logic                   start;
        logic [DIV_REM_W-1:0]   rem;
        logic [DIV_LOW_W-1:0]   low;
        logic [DIV_REM_W-1:0]   divisor;
        logic [DIV_STEPS_W-1:0] steps;
    } t_div_req;

    typedef struct packed {
        logic                 done;
        logic [DIV_LOW_W-1:0] quotient;
    } t_div_rsp;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_SUM,
        S_COST_GO,
        S_COST_WAIT,
        S_WRITE,
        S_RATE_GO,
        S_RATE_WAIT,
        S_OUT
    } t_state;

endpackage

// ----- rtl/acwt_div.sv -----
// restoring divider, one quotient bit per cycle
// depends on acwt_pkg for the request and response types
`timescale 1ns / 1ps

module acwt_div import acwt_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    logic [DIV_REM_W-1:0]   r_rem;
    logic [DIV_LOW_W-1:0]   r_low;
    logic [DIV_REM_W-1:0]   r_div;
    logic [DIV_LOW_W-1:0]   r_quo;
    logic [DIV_STEPS_W-1:0] r_cnt;
    logic                   r_busy;
    logic                   r_done;

    logic [DIV_REM_W:0]     w_trial;
    logic [DIV_REM_W:0]     w_diff;
    logic                   w_fit;

    // trial subtract of the shifted remainder
    always_comb begin
        w_trial = {r_rem, r_low[DIV_LOW_W-1]};
        w_diff  = w_trial - {1'b0, r_div};
        w_fit   = (w_trial >= {1'b0, r_div});
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_req.steps;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == DIV_STEPS_W'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_req.start) begin
            r_rem <= i_req.rem;
            r_low <= i_req.low;
            r_div <= i_req.divisor;
            r_quo <= '0;
        end else if (r_busy) begin
            r_rem <= w_fit ? w_diff[DIV_REM_W-1:0] : w_trial[DIV_REM_W-1:0];
            r_low <= {r_low[DIV_LOW_W-2:0], 1'b0};
            r_quo <= {r_quo[DIV_LOW_W-2:0], w_fit};
        end
    end

    assign o_rsp.done     = r_done;
    assign o_rsp.quotient = r_quo;

endmodule

// ----- rtl/average_cost_win_tracker.sv -----
// channel   direction  payload    handshake
// fill      in         t_fill     i_valid / o_stall
// result    out        t_result   o_valid / i_stall
//
// one fill at a time; a buy runs the shared one-bit-per-cycle divider for the
// new average cost (32 steps), a sell or an ignored fill skips it; every fill
// then runs it for the win rate (17 steps), except while no trade has closed,
// when the win-rate division is skipped
// after reset the position and cost tables are cleared one entry a cycle, the
// whole table, with o_stall high
// a finished result waits in the output register; the next fill is taken
// meanwhile and only its own result waits for the register to free up
// depends on acwt_pkg and acwt_div
`timescale 1ns / 1ps

module average_cost_win_tracker import acwt_pkg::*; #(
    parameter int SYMBOL_COUNT = DEF_SYMBOL_COUNT
) (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_valid,
    output logic    o_stall,
    input  t_fill   i_fill,
    output logic    o_valid,
    input  logic    i_stall,
    output t_result o_result
);

    localparam int IW = $clog2(SYMBOL_COUNT);
    localparam logic [CNT_W-1:0] CNT_MAX = '1;

    // tables
    logic [CNT_W-1:0]   pos_mem  [SYMBOL_COUNT];
    logic [PRICE_W-1:0] cost_mem [SYMBOL_COUNT];

    t_state r_state, n_state;

    logic [IW-1:0]          r_clr_addr;
    logic [IW-1:0]          r_idx;
    logic                   r_sell;
    logic [QTY_W-1:0]       r_qty;
    logic [PRICE_W-1:0]     r_price;
    logic [CNT_W-1:0]       r_held;
    logic [PRICE_W-1:0]     r_cost;
    logic [2*CNT_W-1:0]     r_prod_a;
    logic [QTY_W+PRICE_W-1:0] r_prod_b;
    logic [2*CNT_W:0]       r_sum;
    logic [CNT_W:0]         r_total;
    logic [CNT_W-1:0]       r_new_held;
    logic [PRICE_W-1:0]     r_new_cost;
    logic [CNT_W-1:0]       r_closed;
    logic [CNT_W-1:0]       r_win;
    logic [RATE_W-1:0]      r_rate;
    logic                   r_closed_f;
    logic                   r_won_f;
    logic                   r_out_valid;
    t_result                r_out;

    logic [SYM_W-1:0] s_mod;
    logic [IW-1:0]    w_idx;
    logic             w_skip;
    logic             w_clr_last;
    logic             s_accept;
    logic             s_load_out;
    logic             s_clear_wr;
    logic             s_mem_wr;
    t_div_req         s_div_req;
    t_div_rsp         w_div_rsp;

    // symbol index reduced into the table by conditional subtraction
    always_comb begin
        s_mod = i_fill.symbol_id;
        for (int k = SYM_W - 1; k >= 0; k--) begin
            if (SYMBOL_COUNT < (1 << SYM_W)) begin
                if (32'(s_mod) >= 32'(SYMBOL_COUNT << k)) begin
                    s_mod = s_mod - SYM_W'(SYMBOL_COUNT << k);
                end
            end
        end
    end
    assign w_idx = IW'(s_mod);

    assign w_skip     = (r_qty == '0) || (r_sell && (r_held == '0));
    assign w_clr_last = (r_clr_addr == IW'(SYMBOL_COUNT - 1));

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR:     if (w_clr_last) n_state = S_IDLE;
            S_IDLE:      if (i_valid) n_state = S_READ;
            S_READ: begin
                if (w_skip || r_sell) n_state = S_WRITE;
                else                  n_state = S_SUM;
            end
            S_SUM:       n_state = S_COST_GO;
            S_COST_GO:   n_state = S_COST_WAIT;
            S_COST_WAIT: if (w_div_rsp.done) n_state = S_WRITE;
            S_WRITE:     n_state = S_RATE_GO;
            S_RATE_GO: begin
                if (r_closed == '0) n_state = S_OUT;
                else                n_state = S_RATE_WAIT;
            end
            S_RATE_WAIT: if (w_div_rsp.done) n_state = S_OUT;
            S_OUT:       if (!r_out_valid || !i_stall) n_state = S_IDLE;
            default:     n_state = S_IDLE;
        endcase
    end

    // state outputs
    always_comb begin
        s_accept   = 1'b0;
        s_load_out = 1'b0;
        s_clear_wr = 1'b0;
        s_mem_wr   = 1'b0;
        s_div_req  = '0;
        case (r_state)
            S_CLEAR: s_clear_wr = 1'b1;
            S_IDLE:  s_accept   = i_valid;
            S_COST_GO: begin
                s_div_req.start   = 1'b1;
                s_div_req.rem     = r_sum[2*CNT_W:CNT_W];
                s_div_req.low     = r_sum[CNT_W-1:0];
                s_div_req.divisor = r_total;
                s_div_req.steps   = DIV_STEPS_W'(COST_STEPS);
            end
            S_WRITE: s_mem_wr = 1'b1;
            S_RATE_GO: begin
                s_div_req.start   = (r_closed != '0);
                s_div_req.rem     = DIV_REM_W'(r_win[CNT_W-1:1]);
                s_div_req.low     = {r_win[0], {(DIV_LOW_W-1){1'b0}}};
                s_div_req.divisor = {1'b0, r_closed};
                s_div_req.steps   = DIV_STEPS_W'(RATE_STEPS);
            end
            S_OUT:   s_load_out = !r_out_valid || !i_stall;
            default: s_accept = 1'b0;
        endcase
    end

    assign o_stall = (r_state != S_IDLE);

    // shared divider for average cost and win rate
    acwt_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (s_div_req),
        .o_rsp   (w_div_rsp)
    );

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_clr_addr  <= '0;
            r_closed    <= '0;
            r_win       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (s_clear_wr) r_clr_addr <= r_clr_addr + 1'b1;
            if (r_state == S_READ && !w_skip && r_sell) begin
                if (r_closed != CNT_MAX) r_closed <= r_closed + 1'b1;
                if (r_price > r_cost && r_win != CNT_MAX) r_win <= r_win + 1'b1;
            end
            if (s_load_out)   r_out_valid <= 1'b1;
            else if (!i_stall) r_out_valid <= 1'b0;
        end
    end

    // table access: clear sweep, write back, read on request
    always_ff @(posedge i_clk) begin
        if (s_clear_wr) begin
            pos_mem[r_clr_addr]  <= '0;
            cost_mem[r_clr_addr] <= '0;
        end else if (s_mem_wr) begin
            pos_mem[r_idx]  <= r_new_held;
            cost_mem[r_idx] <= r_new_cost;
        end
        if (s_accept) begin
            r_held <= pos_mem[w_idx];
            r_cost <= cost_mem[w_idx];
        end
    end

    // request capture and arithmetic
    always_ff @(posedge i_clk) begin
        case (r_state)
            S_IDLE: begin
                if (s_accept) begin
                    r_idx      <= w_idx;
                    r_sell     <= (i_fill.func == SIDE_SELL);
                    r_qty      <= i_fill.quantity;
                    r_price    <= i_fill.price;
                    r_closed_f <= 1'b0;
                    r_won_f    <= 1'b0;
                end
            end
            S_READ: begin
                r_prod_a <= (2*CNT_W)'(r_held) * (2*CNT_W)'(r_cost);
                r_prod_b <= (QTY_W+PRICE_W)'(r_qty) * (QTY_W+PRICE_W)'(r_price);
                r_total  <= (CNT_W+1)'(r_held) + (CNT_W+1)'(r_qty);
                if (w_skip) begin
                    r_new_held <= r_held;
                    r_new_cost <= r_cost;
                end else if (r_sell) begin
                    r_closed_f <= 1'b1;
                    r_won_f    <= (r_price > r_cost);
                    if (r_held > CNT_W'(r_qty)) begin
                        r_new_held <= r_held - CNT_W'(r_qty);
                        r_new_cost <= r_cost;
                    end else begin
                        r_new_held <= '0;
                        r_new_cost <= '0;
                    end
                end
            end
            S_SUM: begin
                r_sum      <= (2*CNT_W+1)'(r_prod_a) + (2*CNT_W+1)'(r_prod_b);
                r_new_held <= r_total[CNT_W] ? CNT_MAX : r_total[CNT_W-1:0];
            end
            S_COST_WAIT: begin
                if (w_div_rsp.done) r_new_cost <= w_div_rsp.quotient;
            end
            S_RATE_GO: begin
                if (r_closed == '0) r_rate <= '0;
            end
            S_RATE_WAIT: begin
                if (w_div_rsp.done) r_rate <= w_div_rsp.quotient[RATE_W-1:0];
            end
            default: r_rate <= r_rate;
        endcase
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (s_load_out) begin
            r_out.closed_count  <= r_closed;
            r_out.win_count     <= r_win;
            r_out.win_frac      <= r_rate;
            r_out.trade_closed  <= r_closed_f;
            r_out.trade_won     <= r_won_f;
            r_out.held_quantity <= r_new_held;
            r_out.average_cost  <= r_new_cost;
        end
    end

    assign o_valid  = r_out_valid;
    assign o_result = r_out;

endmodule

// ----- sim/average_cost_win_tracker_tb.sv -----
// self-checking testbench for average_cost_win_tracker: directed fills, then random trade
// episodes and a saturation pile-up checked against an in-bench position book; depends on acwt_pkg and the rtl top
`timescale 1ns / 1ps

module average_cost_win_tracker_tb import acwt_pkg::*; ();

    localparam int          TABLE_DEPTH = DEF_SYMBOL_COUNT;
    localparam logic [31:0] MAX32       = 32'hFFFF_FFFF;
    localparam int          HOLD_CYCLES = 300;
    localparam int          GOAL_FIRST  = 600;
    localparam int          GOAL_TOTAL  = 1450;
    localparam int          PILE_BUYS   = 270;

    typedef struct {
        t_fill   fill;
        bit      known;
        t_result want;
    } t_row;

    logic    i_clk   = 1'b0;
    logic    i_rst_n = 1'b0;
    logic    i_valid = 1'b0;
    logic    i_stall = 1'b0;
    t_fill   i_fill  = '0;
    logic    o_stall;
    logic    o_valid;
    t_result o_result;

    // position book mirrored from accepted fills
    logic [31:0] held_by_sym[TABLE_DEPTH];
    logic [31:0] avg_cost_by_sym[TABLE_DEPTH];
    logic [31:0] closed_total = '0;
    logic [31:0] won_trades   = '0;

    t_result due_results[$];
    t_row    dir_rows[$];
    int      errors        = 0;
    int      live_fills    = 0;
    int      ignored_fills = 0;
    int      results_seen  = 0;
    int      hold_req      = 0;

    average_cost_win_tracker u_top (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_stall  (o_stall),
        .i_fill   (i_fill),
        .o_valid  (o_valid),
        .i_stall  (i_stall),
        .o_result (o_result)
    );

    // 125 MHz clock
    initial begin
        forever #4 i_clk = ~i_clk;
    end

    // generous bound: every fill a buy with worst waits on both sides, plus clear and hold-off
    initial begin
        #6_000_000;
        $display("timeout with %0d results outstanding", due_results.size());
        $display("CHECKS FAILED");
        $finish;
    end

    task automatic report_error(input string msg);
        $display("error: %s", msg);
        errors++;
    endtask

    // applies one fill to the book and returns the result it should produce
    function automatic t_result apply_fill(input t_fill f);
        t_result     r;
        int          idx;
        logic [31:0] held;
        logic [31:0] cost;
        logic [64:0] num;
        logic [64:0] quo;
        logic [32:0] total;
        logic [47:0] scaled;
        idx  = f.symbol_id % TABLE_DEPTH;
        held = held_by_sym[idx];
        cost = avg_cost_by_sym[idx];
        r    = '0;
        if (f.quantity != 0) begin
            if (f.func == SIDE_BUY) begin
                // exact weighted average over the unsaturated total
                num   = 65'(held) * 65'(cost) + 65'(f.quantity) * 65'(f.price);
                total = 33'(held) + 33'(f.quantity);
                quo   = num / 65'(total);
                avg_cost_by_sym[idx] = (quo > 65'(MAX32)) ? MAX32 : quo[31:0];
                held_by_sym[idx]     = total[32] ? MAX32 : total[31:0];
            end else if (held != 0) begin
                r.trade_closed = 1'b1;
                if (closed_total != MAX32) closed_total++;
                if (f.price > cost) begin
                    r.trade_won = 1'b1;
                    if (won_trades != MAX32) won_trades++;
                end
                held = (held > 32'(f.quantity)) ? held - 32'(f.quantity) : '0;
                held_by_sym[idx] = held;
                if (held == 0) avg_cost_by_sym[idx] = '0;
            end
        end
        if (closed_total != 0) begin
            scaled     = {won_trades, 16'h0} / 48'(closed_total);
            r.win_frac = scaled[16:0];
        end
        r.closed_count  = closed_total;
        r.win_count     = won_trades;
        r.held_quantity = held_by_sym[idx];
        r.average_cost  = avg_cost_by_sym[idx];
        return r;
    endfunction

    task automatic check_result(input t_result got, input t_result want);
        if (got.closed_count !== want.closed_count)
            report_error($sformatf("result %0d closed_count %0h, expected %0h",
                results_seen, got.closed_count, want.closed_count));
        if (got.win_count !== want.win_count)
            report_error($sformatf("result %0d win_count %0h, expected %0h",
                results_seen, got.win_count, want.win_count));
        if (got.win_frac !== want.win_frac)
            report_error($sformatf("result %0d win_frac %0h, expected %0h",
                results_seen, got.win_frac, want.win_frac));
        if (got.trade_closed !== want.trade_closed)
            report_error($sformatf("result %0d trade_closed %b, expected %b",
                results_seen, got.trade_closed, want.trade_closed));
        if (got.trade_won !== want.trade_won)
            report_error($sformatf("result %0d trade_won %b, expected %b",
                results_seen, got.trade_won, want.trade_won));
        if (got.held_quantity !== want.held_quantity)
            report_error($sformatf("result %0d held_quantity %0h, expected %0h",
                results_seen, got.held_quantity, want.held_quantity));
        if (got.average_cost !== want.average_cost)
            report_error($sformatf("result %0d average_cost %0h, expected %0h",
                results_seen, got.average_cost, want.average_cost));
    endtask

    // idle cycles per request; some stretches run with no idling at all
    function automatic int draw_wait();
        if (((live_fills / 120) % 4) == 2) return 0;
        return $urandom_range(0, 11);
    endfunction

    function automatic t_fill make_fill(input logic [7:0] sym, input logic side,
                                        input logic [23:0] qty, input logic [31:0] price);
        t_fill f;
        f.symbol_id = sym;
        f.func      = side;
        f.quantity  = qty;
        f.price     = price;
        return f;
    endfunction

    function automatic t_result outcome(input logic [31:0] closed, input logic [31:0] won,
                                        input logic [16:0] rate, input logic tc,
                                        input logic tw, input logic [31:0] held,
                                        input logic [31:0] cost);
        return t_result'{closed, won, rate, tc, tw, held, cost};
    endfunction

    function automatic void add_row(input logic [7:0] sym, input logic side,
                                    input logic [23:0] qty, input logic [31:0] price,
                                    input bit known = 1'b0, input t_result want = '0);
        t_row row;
        row.fill  = make_fill(sym, side, qty, price);
        row.known = known;
        row.want  = want;
        dir_rows.insert(dir_rows.size(), row);
    endfunction

    function automatic logic [23:0] draw_qty();
        int r;
        r = $urandom_range(0, 99);
        if (r < 4) return '0;
        if (r < 45) return 24'($urandom_range(1, 100));
        if (r < 75) return 24'($urandom_range(1, 65535));
        return 24'($urandom_range(1, 24'hFF_FFFF));
    endfunction

    // prices cluster around the symbol's average cost so wins, losses and ties all occur
    function automatic logic [31:0] draw_price(input int sym);
        logic [31:0] c;
        int          r;
        c = avg_cost_by_sym[sym];
        r = $urandom_range(0, 99);
        if (c == 0 || r < 25) return $urandom;
        if (r < 35) return '0;
        if (r < 45) return MAX32;
        if (r < 65) return c;
        return c + $urandom_range(0, 6) - 3;
    endfunction

    // offer one fill, wait for it to be taken, then record what it should return
    task automatic send_fill(input t_fill f, input bit known = 1'b0,
                             input t_result want = '0);
        int      gap;
        bit      live;
        t_result pred;
        gap = draw_wait();
        if (gap != 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_valid <= 1'b1;
        i_fill  <= f;
        @(posedge i_clk);
        while (o_stall) @(posedge i_clk);
        live = (f.quantity != 0) &&
               (f.func == SIDE_BUY || held_by_sym[f.symbol_id % TABLE_DEPTH] != 0);
        if (live) live_fills++;
        else ignored_fills++;
        pred = apply_fill(f);
        due_results.insert(due_results.size(), known ? want : pred);
    endtask

    // sender goes quiet until every pending result has come back
    task automatic drain_results();
        i_valid <= 1'b0;
        while (due_results.size() != 0) @(posedge i_clk);
    endtask

    // buy-then-sell episodes on a few busy symbols, with some random noise fills
    task automatic run_episodes(input int goal);
        int          sym;
        int          nbuys;
        int          nsells;
        logic [23:0] qty;
        while ((live_fills + ignored_fills) < goal) begin
            sym = ($urandom_range(0, 3) != 0) ? $urandom_range(0, 7) : $urandom_range(0, 255);
            if ($urandom_range(0, 9) == 0) begin
                send_fill(make_fill(8'($urandom), 1'($urandom), 24'($urandom), $urandom));
            end else begin
                nbuys = $urandom_range(1, 4);
                repeat (nbuys)
                    send_fill(make_fill(8'(sym), SIDE_BUY, draw_qty(), draw_price(sym)));
                nsells = 0;
                while (held_by_sym[sym] != 0 && nsells < 6) begin
                    if ($urandom_range(0, 3) == 0)
                        qty = (held_by_sym[sym] > 32'hFF_FFFF) ? 24'hFF_FFFF
                                                                : held_by_sym[sym][23:0];
                    else
                        qty = draw_qty();
                    send_fill(make_fill(8'(sym), SIDE_SELL, qty, draw_price(sym)));
                    nsells++;
                end
                // sometimes one more sell lands on the position, which may be empty by now
                if ($urandom_range(0, 4) == 0)
                    send_fill(make_fill(8'(sym), SIDE_SELL, draw_qty(), $urandom));
            end
        end
    endtask

    // result side: random stalls per request, plus one long hold-off on demand
    initial begin : result_side
        int      wait_cycles;
        t_result want;
        @(posedge i_clk iff i_rst_n);
        forever begin
            if (hold_req != 0) begin
                wait_cycles = hold_req;
                hold_req    = 0;
            end else begin
                wait_cycles = draw_wait();
            end
            if (wait_cycles != 0) begin
                i_stall <= 1'b1;
                repeat (wait_cycles) @(posedge i_clk);
            end
            i_stall <= 1'b0;
            @(posedge i_clk);
            while (!o_valid) @(posedge i_clk);
            results_seen++;
            if (due_results.size() == 0) begin
                report_error($sformatf("result %0d arrived with no fill pending",
                    results_seen));
            end else begin
                want = due_results.pop_front();
                check_result(o_result, want);
            end
        end
    end

    // fill side: reset, directed rows, random episodes, saturation pile-up
    initial begin : fill_side
        int sym;
        for (int k = 0; k < TABLE_DEPTH; k++) begin
            held_by_sym[k]     = '0;
            avg_cost_by_sym[k] = '0;
        end

        // ignored fills right after reset
        add_row(8'd0, SIDE_BUY, 24'd0, 32'd0, 1'b1, outcome(0, 0, 0, 0, 0, 0, 0));
        add_row(8'd0, SIDE_SELL, 24'd5, 32'd100, 1'b1, outcome(0, 0, 0, 0, 0, 0, 0));
        // largest buy on the last symbol, then a losing sell of one unit
        add_row(8'd255, SIDE_BUY, 24'hFF_FFFF, MAX32, 1'b1,
                outcome(0, 0, 0, 0, 0, 32'h00FF_FFFF, MAX32));
        add_row(8'd255, SIDE_SELL, 24'd1, 32'd0, 1'b1,
                outcome(1, 0, 0, 1, 0, 32'h00FF_FFFE, MAX32));
        // zero-price buy, then an oversell that wins and clears the position
        add_row(8'd1, SIDE_BUY, 24'd1, 32'd0, 1'b1, outcome(1, 0, 0, 0, 0, 1, 0));
        add_row(8'd1, SIDE_SELL, 24'hFF_FFFF, MAX32, 1'b1,
                outcome(2, 1, 17'd32768, 1, 1, 0, 0));
        // averaging up, tie at cost, win one above, exact close
        add_row(8'd2, SIDE_BUY, 24'd10, 32'h0001_0000, 1'b1,
                outcome(2, 1, 17'd32768, 0, 0, 10, 32'h0001_0000));
        add_row(8'd2, SIDE_BUY, 24'd30, 32'h0002_0000);
        add_row(8'd2, SIDE_SELL, 24'd5, 32'h0001_C000);
        add_row(8'd2, SIDE_SELL, 24'd5, 32'h0001_C001);
        add_row(8'd2, SIDE_SELL, 24'd30, 32'd0);
        // zero quantity on a held position, either side
        add_row(8'd3, SIDE_BUY, 24'd7, 32'h0001_2345);
        add_row(8'd3, SIDE_BUY, 24'd0, MAX32);
        add_row(8'd3, SIDE_SELL, 24'd0, MAX32);
        // truncating division on an uneven blend
        add_row(8'd128, SIDE_BUY, 24'd1, 32'd1);
        add_row(8'd128, SIDE_BUY, 24'hFF_FFFF, MAX32);
        add_row(8'd128, SIDE_SELL, 24'd1, MAX32);
        // alternating bit patterns in every field
        add_row(8'hAA, SIDE_BUY, 24'h55_5555, 32'hAAAA_AAAA);
        add_row(8'h55, SIDE_BUY, 24'hAA_AAAA, 32'h5555_5555);
        add_row(8'h55, SIDE_SELL, 24'hAA_AAAA, 32'h5555_5554);

        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[k]) send_fill(dir_rows[k].fill, dir_rows[k].known, dir_rows[k].want);
        drain_results();

        // long receiver hold-off while fills keep coming
        hold_req = HOLD_CYCLES;
        run_episodes(GOAL_FIRST);
        drain_results();

        // pile buys onto one symbol until held quantity saturates and the sum overflows
        sym = $urandom_range(200, 255);
        repeat (PILE_BUYS)
            send_fill(make_fill(8'(sym), SIDE_BUY, 24'hFF_FFFF,
                                MAX32 - $urandom_range(0, 255)));
        repeat (3) send_fill(make_fill(8'(sym), SIDE_SELL, draw_qty(), $urandom));

        run_episodes(GOAL_TOTAL);
        drain_results();
        repeat (150) @(posedge i_clk);

        $display("run: %0d position-changing fills, %0d ignored fills, %0d results checked",
                 live_fills, ignored_fills, results_seen);
        $display("book: %0d closed trades, %0d wins, held quantity saturated on symbol %0d",
                 closed_total, won_trades, sym);
        if (errors == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule
